[rtl/chs_pkg.sv]
`timescale 1ns / 1ps
package chs_pkg;
	localparam int BUCKETS    = 64;
	localparam int POOL_NODES = 256;
	localparam int KEY_BITS   = 32;
	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int NODE_W = $clog2(POOL_NODES);
	localparam int PTR_W  = NODE_W + 1;
	localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

	localparam logic [1:0] REQ_SEARCH = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request, start head read
		logic clr_head;   // clearing pass write
		logic head;       // take head read as first chain node
		logic cmp;        // compare node key, follow link on a miss
		logic do_ins;     // write new node, link it at head if chain empty
		logic tail;       // link new node behind old tail
		logic do_rem;     // unlink hit node, push it on freed stack
		logic finish;     // capture result
	} chs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cur_nil;
		logic key_hit;
		logic clr_done;
		logic found;
		logic node_avail;
	} chs_sts_t;
endpackage

[rtl/chs_ram.sv]
`timescale 1ns / 1ps
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/chs_datapath.sv]
`timescale 1ns / 1ps
module chs_datapath import chs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  chs_cmd_t            cmd,
	output chs_sts_t            sts,
	input  logic [1:0]          req_type,
	input  logic [KEY_BITS-1:0] key,
	output logic [1:0]          res_status,
	output logic [KEY_BITS-1:0] res_key
);
	logic [1:0]          req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [BKT_W-1:0]    bkt_q;
	logic [PTR_W-1:0]    cur_q, prev_q, next_q;
	logic                found_q;
	logic [BKT_W-1:0]    clr_q;
	logic                clr_done_q;
	logic [PTR_W-1:0]    freed_cnt_q, fresh_q;
	logic                tail_q;
	logic [PTR_W-1:0]    tail_node_q;
	logic [1:0]          st_q;

	// bucket of a signed key: low bits of two's complement give the
	// non-negative remainder for a power-of-two bucket count
	logic [BKT_W-1:0] bkt_in;
	assign bkt_in = key[BKT_W-1:0];

	logic              h_we;
	logic [BKT_W-1:0]  h_wa, h_ra;
	logic [PTR_W-1:0]  h_wd, h_rd;
	logic              k_we, l_we, f_we;
	logic [NODE_W-1:0] k_wa, l_wa, f_wa, n_ra, f_ra;
	logic [PTR_W-1:0]  l_wd, l_rd;
	logic [KEY_BITS-1:0] k_rd;
	logic [NODE_W-1:0] f_wd, f_rd;
	logic [PTR_W-1:0]  new_node;
	logic              freed_avail;

	chs_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_heads (
		.clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
	chs_ram #(.WIDTH(KEY_BITS), .DEPTH(POOL_NODES)) u_keys (
		.clk, .we(k_we), .waddr(k_wa), .wdata(key_q), .raddr(n_ra), .rdata(k_rd));
	chs_ram #(.WIDTH(PTR_W), .DEPTH(POOL_NODES)) u_links (
		.clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(n_ra), .rdata(l_rd));
	chs_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_freed (
		.clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

	assign h_ra = bkt_in;
	assign n_ra = cur_q[NODE_W-1:0];
	// stack top is read all through the walk; the count only moves at the end
	assign f_ra = NODE_W'(freed_cnt_q - PTR_W'(1));
	assign f_wa = freed_cnt_q[NODE_W-1:0];
	assign f_wd = cur_q[NODE_W-1:0];
	assign k_wa = new_node[NODE_W-1:0];

	assign freed_avail = freed_cnt_q != '0;
	assign new_node = freed_avail ? {1'b0, f_rd} : fresh_q;

	always_comb begin
		h_we = 1'b0; h_wa = bkt_q; h_wd = NIL;
		k_we = 1'b0;
		l_we = 1'b0; l_wa = new_node[NODE_W-1:0]; l_wd = NIL;
		f_we = 1'b0;
		if (cmd.clr_head) begin
			h_we = 1'b1; h_wa = clr_q;
		end else if (cmd.do_ins) begin
			k_we = 1'b1;
			l_we = 1'b1;
			if (prev_q == NIL) begin
				h_we = 1'b1; h_wd = new_node;
			end
		end else if (cmd.do_rem) begin
			f_we = freed_cnt_q != NIL;
			if (prev_q == NIL) begin
				h_we = 1'b1; h_wd = next_q;
			end else begin
				l_we = 1'b1; l_wa = prev_q[NODE_W-1:0]; l_wd = next_q;
			end
		end else if (cmd.tail && tail_q) begin
			// one link write port: the old tail is linked in S_FIN, after the new node is written in S_ACT
			l_we = 1'b1; l_wa = prev_q[NODE_W-1:0]; l_wd = tail_node_q;
		end
	end

	assign sts.cur_nil    = cur_q == NIL;
	assign sts.key_hit    = k_rd == key_q;
	assign sts.clr_done   = clr_done_q;
	assign sts.found      = found_q;
	assign sts.node_avail = freed_avail || fresh_q != NIL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			clr_done_q  <= 1'b0;
			freed_cnt_q <= '0;
			fresh_q     <= '0;
			tail_q      <= 1'b0;
		end else begin
			if (cmd.clr_head) begin
				clr_q <= clr_q + BKT_W'(1);
				if (clr_q == BKT_W'(BUCKETS - 1)) clr_done_q <= 1'b1;
			end
			if (cmd.load) tail_q <= 1'b0;
			if (cmd.do_ins) begin
				tail_q <= prev_q != NIL;
				if (freed_avail) freed_cnt_q <= freed_cnt_q - PTR_W'(1);
				else fresh_q <= fresh_q + PTR_W'(1);
			end
			if (cmd.do_rem && freed_cnt_q != NIL) freed_cnt_q <= freed_cnt_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			key_q   <= key;
			bkt_q   <= bkt_in;
			found_q <= 1'b0;
		end
		if (cmd.head) begin
			cur_q  <= h_rd;
			prev_q <= NIL;
		end
		if (cmd.cmp) begin
			// on a hit cur/prev stay put: hit node and its predecessor
			if (sts.key_hit) begin
				found_q <= 1'b1;
				next_q  <= l_rd;
			end else begin
				prev_q <= cur_q;
				cur_q  <= l_rd;
			end
		end
		if (cmd.do_ins) tail_node_q <= new_node;
		if (cmd.finish) begin
			res_key <= key_q;
			case (req_q)
				REQ_SEARCH: begin
					st_q <= found_q ? ST_OK : ST_ABSENT;
					if (!found_q) res_key <= '1;
				end
				REQ_INSERT: st_q <= (found_q || sts.node_avail) ? ST_OK : ST_FULL;
				REQ_REMOVE: st_q <= found_q ? ST_OK : ST_ABSENT;
				default:    st_q <= ST_ABSENT;
			endcase
		end
	end
	assign res_status = st_q;
endmodule

[rtl/chs_ctrl.sv]
`timescale 1ns / 1ps
module chs_ctrl import chs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  logic [1:0] req_type,
	output chs_cmd_t cmd,
	input  chs_sts_t sts
);
	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_HEAD  = 7'b0000100,
		S_READ  = 7'b0001000,
		S_CMP   = 7'b0010000,
		S_ACT   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t    state_q, state_d;
	logic [1:0] req_q;
	logic       ov_q;

	assign in_stall  = state_q != S_IDLE || ov_q;
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_done) state_d = S_IDLE;
				else cmd.clr_head = 1'b1;
			end
			S_IDLE: if (in_valid && !ov_q) begin
				cmd.load = 1'b1;
				state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.head = 1'b1;
				state_d = S_READ;
			end
			S_READ: state_d = sts.cur_nil ? S_ACT : S_CMP;
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = sts.key_hit ? S_ACT : S_READ;
			end
			S_ACT: begin
				cmd.finish = 1'b1;
				case (req_q)
					REQ_INSERT: cmd.do_ins = !sts.found && sts.node_avail;
					REQ_REMOVE: cmd.do_rem = sts.found;
					default: ;
				endcase
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.tail = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req_type;
	end
endmodule

[rtl/chained_hash_set_core.sv]
`timescale 1ns / 1ps
// Sequence: accept, S_HEAD, S_READ and S_CMP for each chain node walked, a final S_READ on
// reaching the chain end on a miss, then S_ACT and S_FIN; a hit leaves the walk from S_CMP.
// Throughput: one item at a time; the chain walk (a read and a compare per node) sets it,
// and the next item is taken only after the result has left and out_valid has dropped.
// Reset: a clearing pass of 64 head writes before the first item is taken.
module chained_hash_set_core import chs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [KEY_BITS-1:0] key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [KEY_BITS-1:0] result_key
);
	chs_cmd_t cmd;
	chs_sts_t sts;

	chs_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.req_type, .cmd, .sts);
	chs_datapath u_dp (.clk, .arst_n, .cmd, .sts, .req_type, .key,
		.res_status(status), .res_key(result_key));
endmodule

[rtl/chs_checker.sv]
`timescale 1ns / 1ps
module chs_checker import chs_pkg::*; (
	input logic clk, arst_n, in_stall, out_valid, out_stall,
	input logic [1:0] status,
	input logic [KEY_BITS-1:0] result_key
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(result_key))
		else $error("stalled result changed");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept while result waits");
endmodule
bind chained_hash_set_core chs_checker u_chk (.clk, .arst_n, .in_stall,
	.out_valid, .out_stall, .status, .result_key);

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import chs_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          req_type = '0;
	logic [KEY_BITS-1:0] key = '0;
	logic                out_valid;
	logic                out_stall = 1'b1;
	logic [1:0]          status;
	logic [KEY_BITS-1:0] result_key;

	chained_hash_set_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .key(key),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .result_key(result_key)
	);

	always #4 clk = ~clk;

	typedef struct packed {
		logic [1:0]          op;
		logic [KEY_BITS-1:0] k;
	} req_item_t;

	typedef struct packed {
		logic [1:0]          st;
		logic [KEY_BITS-1:0] rk;
	} resp_item_t;

	// shadow of the table
	logic [PTR_W-1:0]    heads [BUCKETS];
	logic [KEY_BITS-1:0] nkey  [POOL_NODES];
	logic [PTR_W-1:0]    nlink [POOL_NODES];
	logic [NODE_W-1:0]   fstack[POOL_NODES];
	int unsigned         fcount;
	int unsigned         fresh;

	req_item_t  pending_reqs[$];
	resp_item_t expected_resps[$];
	int         errors = 0;
	int         snd_idle_pct = 23;
	int         rcv_idle_pct = 46;
	int         quiet_cycles = 0;
	logic [KEY_BITS-1:0] key_pool[16];

	function automatic int unsigned bucket_index(logic [KEY_BITS-1:0] k);
		logic [KEY_BITS-1:0] mag;
		int unsigned r;
		if (k[KEY_BITS-1]) begin
			mag = -k;
			r = mag % BUCKETS;
			return (r != 0) ? BUCKETS - r : 0;
		end
		return k % BUCKETS;
	endfunction

	function automatic resp_item_t apply_request(req_item_t rq);
		resp_item_t  rs;
		int unsigned b;
		logic [PTR_W-1:0] cur, prev, n;
		int steps;
		b = bucket_index(rq.k);
		cur = heads[b];
		prev = NIL;
		steps = 0;
		while (cur < NIL && steps < POOL_NODES && nkey[cur] != rq.k) begin
			prev = cur;
			cur = nlink[cur];
			steps++;
		end
		if (!(cur < NIL && nkey[cur] == rq.k))
			cur = NIL;
		rs.st = ST_ABSENT;
		rs.rk = rq.k;
		case (rq.op)
			REQ_SEARCH: begin
				if (cur < NIL) rs.st = ST_OK;
				else rs.rk = '1;
			end
			REQ_INSERT: begin
				if (cur < NIL) rs.st = ST_OK;
				else begin
					n = NIL;
					if (fcount > 0) begin
						fcount--;
						n = PTR_W'(fstack[fcount]);
					end else if (fresh < POOL_NODES) begin
						n = PTR_W'(fresh);
						fresh++;
					end
					if (n < NIL) begin
						nkey[n] = rq.k;
						nlink[n] = NIL;
						if (prev < NIL) nlink[prev] = n;
						else heads[b] = n;
						rs.st = ST_OK;
					end else rs.st = ST_FULL;
				end
			end
			REQ_REMOVE: begin
				if (cur < NIL) begin
					if (prev < NIL) nlink[prev] = nlink[cur];
					else heads[b] = nlink[cur];
					if (fcount < POOL_NODES) begin
						fstack[fcount] = cur[NODE_W-1:0];
						fcount++;
					end
					rs.st = ST_OK;
				end
			end
			default: ;
		endcase
		return rs;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!(in_valid && in_stall)) begin
				if (pending_reqs.size() > 0 &&
				    $urandom_range(99) >= snd_idle_pct) begin
					in_valid <= 1'b1;
					req_type <= pending_reqs[0].op;
					key <= pending_reqs[0].k;
					expected_resps.push_back(apply_request(pending_reqs.pop_front()));
				end else
					in_valid <= 1'b0;
			end
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 20000) begin
				$display("testbench: FAIL");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (expected_resps.size() == 0) begin
					$display("%0t: unexpected item exp none got st=%0d key=%h", $time,
					         status, result_key);
					errors++;
				end else begin
					if (status !== expected_resps[0].st) begin
						$display("%0t: status exp %0d got %0d", $time,
						         expected_resps[0].st, status);
						errors++;
					end
					if (result_key !== expected_resps[0].rk) begin
						$display("%0t: result_key exp %h got %h", $time,
						         expected_resps[0].rk, result_key);
						errors++;
					end
					void'(expected_resps.pop_front());
				end
			end
		end
	end

	task automatic add_req(logic [1:0] op, logic [KEY_BITS-1:0] k);
		req_item_t r;
		r.op = op;
		r.k = k;
		pending_reqs.push_back(r);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic random_phase(int count);
		int  i;
		int  sel;
		logic [KEY_BITS-1:0] k;
		for (i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 80) k = key_pool[$urandom_range(15)];
			else k = $urandom();
			sel = $urandom_range(99);
			if (sel < 45) add_req(REQ_INSERT, k);
			else if (sel < 70) add_req(REQ_SEARCH, k);
			else if (sel < 95) add_req(REQ_REMOVE, k);
			else add_req(REQ_UNUSED, k);
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < BUCKETS; i++) heads[i] = NIL;
		fcount = 0;
		fresh = 0;
		// keys sharing bucket 0 plus a few others, both signs
		for (i = 0; i < 16; i++)
			key_pool[i] = (i < 8) ? KEY_BITS'(i * BUCKETS) : KEY_BITS'(-(i * 37 + 1));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		add_req(REQ_SEARCH, 32'h8000_0000);
		add_req(REQ_INSERT, 32'h8000_0000);
		add_req(REQ_INSERT, 32'h7fff_ffff);
		add_req(REQ_INSERT, 32'hffff_ffff);
		add_req(REQ_INSERT, 32'h0000_0000);
		add_req(REQ_INSERT, 32'h0000_0040);
		add_req(REQ_INSERT, 32'hffff_ffc0);
		add_req(REQ_INSERT, 32'h0000_0040);   // duplicate
		add_req(REQ_SEARCH, 32'h0000_0040);
		add_req(REQ_SEARCH, 32'h7fff_ffff);
		add_req(REQ_SEARCH, 32'h1234_5678);
		add_req(REQ_REMOVE, 32'h0000_0000);   // second in chain, behind 8000_0000
		add_req(REQ_REMOVE, 32'h0000_0000);   // now absent
		add_req(REQ_REMOVE, 32'hffff_ffc0);   // tail
		add_req(REQ_UNUSED, 32'h5555_aaaa);
		add_req(REQ_INSERT, 32'haaaa_5555);   // reuses freed node
		add_req(REQ_SEARCH, 32'hffff_ffff);
		// sender waits here until every result is back
		drain();

		// exhaust the pool
		for (i = 0; i < POOL_NODES + 4; i++) add_req(REQ_INSERT, 32'h1000_0000 + i);
		add_req(REQ_SEARCH, 32'h1000_0005);
		for (i = 0; i < POOL_NODES + 4; i++) add_req(REQ_REMOVE, 32'h1000_0000 + i);
		drain();

		random_phase(150);
		drain();
		snd_idle_pct = 46;
		rcv_idle_pct = 23;
		random_phase(150);
		drain();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		random_phase(150);
		drain();
		repeat (600) @(posedge clk);
		if (errors == 0 && expected_resps.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
